>>> hdl/klerp_pkg.sv
// Shared types and constants for the 2D keyframe interpolator.
// No dependencies; used by klerp_ctrl, klerp_dp and keyframe_lerp_2d_unit.
`timescale 1ns / 1ps
`default_nettype none

package klerp_pkg;

  localparam int MAX_KEYS_DEFAULT = 64;

  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int T_W     = 16;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int PROD_W  = DIFF_W + T_W + 1;
  localparam int STEP_W  = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic load_f;
    logic cap_left;
    logic cap_right;
    logic div_init;
    logic div_step;
    logic mul_x;
    logic mul_y;
    logic add_x;
    logic add_y;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic key_le_f;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/klerp_dp.sv
// Datapath of the keyframe interpolator: entry memory, key compare,
// serial divider, shared multiplier and output register. Uses klerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module klerp_dp #(
  parameter int MAX_KEYS = klerp_pkg::MAX_KEYS_DEFAULT,
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire klerp_pkg::dp_cmd_t                  cmd,
  output klerp_pkg::dp_status_t                    status,
  input  wire logic [AW-1:0]                       rd_addr,
  input  wire logic [klerp_pkg::IDX_W-1:0]         entry_index,
  input  wire logic signed [klerp_pkg::KEY_W-1:0]  key_in,
  input  wire logic signed [klerp_pkg::VAL_W-1:0]  value_x_in,
  input  wire logic signed [klerp_pkg::VAL_W-1:0]  value_y_in,
  input  wire logic signed [klerp_pkg::KEY_W-1:0]  fraction,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [klerp_pkg::VAL_W-1:0]       out_x,
  output logic signed [klerp_pkg::VAL_W-1:0]       out_y
);

  klerp_pkg::entry_t mem [MAX_KEYS];
  klerp_pkg::entry_t rd_q;

  logic signed [klerp_pkg::KEY_W-1:0]  f;
  logic signed [klerp_pkg::KEY_W-1:0]  kl;
  logic signed [klerp_pkg::KEY_W-1:0]  kr;
  logic signed [klerp_pkg::VAL_W-1:0]  vxl;
  logic signed [klerp_pkg::VAL_W-1:0]  vyl;
  logic signed [klerp_pkg::VAL_W-1:0]  vxr;
  logic signed [klerp_pkg::VAL_W-1:0]  vyr;

  logic [klerp_pkg::T_W:0]             rem;
  logic [klerp_pkg::T_W-1:0]           den;
  logic [klerp_pkg::T_W-1:0]           quo;
  logic                                tz;
  logic [klerp_pkg::T_W:0]             rem2;
  logic                                ge;

  logic signed [klerp_pkg::DIFF_W-1:0] dx;
  logic signed [klerp_pkg::DIFF_W-1:0] dy;
  logic signed [klerp_pkg::DIFF_W-1:0] d_sel;
  logic signed [klerp_pkg::T_W:0]      t_s;
  logic signed [klerp_pkg::PROD_W-1:0] prod;
  logic signed [klerp_pkg::VAL_W-1:0]  res_x;
  logic signed [klerp_pkg::VAL_W-1:0]  res_y;

  logic                                wr_ok;
  logic [AW-1:0]                       waddr;

  assign wr_ok = cmd.wr && (32'(entry_index) < 32'(MAX_KEYS));
  assign waddr = AW'(entry_index);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[waddr] <= '{key: key_in, x: value_x_in, y: value_y_in};
    end
    rd_q <= mem[rd_addr];
  end

  assign status.key_le_f = (rd_q.key <= f);
  assign status.out_free = !out_valid || out_ready;

  // restoring divide, one quotient bit per step
  assign rem2 = {rem[klerp_pkg::T_W-1:0], 1'b0};
  assign ge   = (rem2 >= {1'b0, den});

  assign dx    = klerp_pkg::DIFF_W'(vxr) - klerp_pkg::DIFF_W'(vxl);
  assign dy    = klerp_pkg::DIFF_W'(vyr) - klerp_pkg::DIFF_W'(vyl);
  assign d_sel = cmd.mul_y ? dy : dx;
  assign t_s   = {1'b0, (tz ? '0 : quo)};

  always_ff @(posedge clk) begin
    if (cmd.load_f) begin
      f <= fraction;
    end
    if (cmd.cap_left) begin
      kl  <= rd_q.key;
      vxl <= rd_q.x;
      vyl <= rd_q.y;
    end
    if (cmd.cap_right) begin
      kr  <= rd_q.key;
      vxr <= rd_q.x;
      vyr <= rd_q.y;
    end
    if (cmd.div_init) begin
      rem <= {1'b0, klerp_pkg::T_W'(f - kl)};
      den <= klerp_pkg::T_W'(kr - kl);
      quo <= '0;
      tz  <= !((kr > kl) && (f >= kl));
    end else if (cmd.div_step) begin
      rem <= ge ? (rem2 - {1'b0, den}) : rem2;
      quo <= {quo[klerp_pkg::T_W-2:0], ge};
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod <= klerp_pkg::PROD_W'(d_sel) * klerp_pkg::PROD_W'(t_s);
    end
    if (cmd.add_x) begin
      res_x <= vxl + prod[klerp_pkg::VAL_W+klerp_pkg::T_W-1:klerp_pkg::T_W];
    end
    if (cmd.add_y) begin
      res_y <= vyl + prod[klerp_pkg::VAL_W+klerp_pkg::T_W-1:klerp_pkg::T_W];
    end
    if (cmd.out_load) begin
      out_x <= res_x;
      out_y <= res_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/klerp_ctrl.sv
// Controller of the keyframe interpolator: count registers, key scan,
// divider sequencing and result hand-off. Uses klerp_pkg; drives klerp_dp.
`timescale 1ns / 1ps
`default_nettype none

module klerp_ctrl #(
  parameter int MAX_KEYS = klerp_pkg::MAX_KEYS_DEFAULT,
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [klerp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [klerp_pkg::CNT_W-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                func,
  output klerp_pkg::dp_cmd_t                       cmd,
  input  wire klerp_pkg::dp_status_t               status,
  output logic [AW-1:0]                            rd_addr
);

  typedef enum logic [10:0] {
    IDLE      = 11'b000_0000_0001,
    SCAN      = 11'b000_0000_0010,
    RD_LEFT   = 11'b000_0000_0100,
    RD_RIGHT  = 11'b000_0000_1000,
    CAP_RIGHT = 11'b000_0001_0000,
    DIV_INIT  = 11'b000_0010_0000,
    DIV       = 11'b000_0100_0000,
    MUL_X     = 11'b000_1000_0000,
    MUL_Y     = 11'b001_0000_0000,
    ADD_Y     = 11'b010_0000_0000,
    FINISH    = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [klerp_pkg::CNT_W-1:0]  key_count;
  logic [klerp_pkg::CNT_W-1:0]  value_count;
  logic [AW-1:0]                cidx;
  logic [AW-1:0]                left;
  logic [AW-1:0]                right;
  logic                         found;
  logic [klerp_pkg::STEP_W-1:0] step;

  logic                         accept;
  logic                         eval_ok;
  logic [AW-1:0]                n_last;
  logic [31:0]                  n_last_w;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign eval_ok  = (key_count == value_count) && (key_count != '0);
  assign n_last_w = (32'(key_count) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS - 1)
                                                     : 32'(key_count) - 32'd1;
  assign n_last   = AW'(n_last_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= '0;
      value_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        klerp_pkg::REG_KEY_COUNT:   key_count   <= cfg_data;
        klerp_pkg::REG_VALUE_COUNT: value_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    rd_addr    = '0;
    unique case (state)
      IDLE: begin
        if (accept) begin
          if (func == klerp_pkg::FUNC_WRITE) begin
            cmd.wr = 1'b1;
          end else if (eval_ok) begin
            cmd.load_f = 1'b1;
            state_next = SCAN;
          end
        end
      end
      SCAN: begin
        rd_addr = cidx + AW'(1);
        if (!status.key_le_f || cidx == n_last) begin
          state_next = RD_LEFT;
        end
      end
      RD_LEFT: begin
        rd_addr = left;
        state_next = RD_RIGHT;
      end
      RD_RIGHT: begin
        rd_addr = right;
        cmd.cap_left = 1'b1;
        state_next = CAP_RIGHT;
      end
      CAP_RIGHT: begin
        cmd.cap_right = 1'b1;
        state_next = DIV_INIT;
      end
      DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (step == '1) begin
          state_next = MUL_X;
        end
      end
      MUL_X: begin
        cmd.mul_x = 1'b1;
        state_next = MUL_Y;
      end
      MUL_Y: begin
        cmd.mul_y = 1'b1;
        cmd.add_x = 1'b1;
        state_next = ADD_Y;
      end
      ADD_Y: begin
        cmd.add_y = 1'b1;
        state_next = FINISH;
      end
      FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cidx  <= '0;
      left  <= '0;
      right <= '0;
      found <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        IDLE: begin
          cidx  <= '0;
          left  <= '0;
          found <= 1'b0;
        end
        SCAN: begin
          if (status.key_le_f) begin
            left  <= cidx;
            found <= 1'b1;
            cidx  <= cidx + AW'(1);
          end
        end
        RD_LEFT: begin
          // right neighbour, clamped to the last key in use
          if (!found || left == n_last) begin
            right <= left;
          end else begin
            right <= left + AW'(1);
          end
        end
        DIV_INIT: step <= '0;
        DIV:      step <= step + klerp_pkg::STEP_W'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output register busy");

  a_left_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == RD_LEFT) |-> (left <= n_last))
    else $error("left index beyond last key");

  a_right_neighbour: assert property (@(posedge clk) disable iff (rst)
    (state == RD_RIGHT) |-> ((right == left) || (right == left + AW'(1))))
    else $error("right index not next to left");

  a_bad_counts_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && func == klerp_pkg::FUNC_EVAL && !eval_ok) |=> (state == IDLE))
    else $error("evaluate with unusable counts left idle");
`endif

endmodule

`default_nettype wire

>>> hdl/keyframe_lerp_2d_unit.sv
// Top level of the 2D keyframe interpolator.
// Depends on klerp_pkg, klerp_ctrl and klerp_dp.
`timescale 1ns / 1ps
`default_nettype none

// A write transaction (func 0) stores a key and an x,y value at entry_index.
// An evaluate transaction (func 1) scans the keys one per cycle from entry 0
// until the first key above the fraction or the last key in use, then reads
// the two neighbours, runs a 16-step divide for t and does two multiplies on a
// shared multiplier. The single read port of the entry memory and the serial
// divider set how long an evaluate takes. An evaluate with key_count and
// value_count unequal or zero gives no result. The result waits in an output
// register, so the next transaction is taken while it is still pending.
// Set the counts only while the block is idle.
module keyframe_lerp_2d_unit #(
  parameter int MAX_KEYS = klerp_pkg::MAX_KEYS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [klerp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [klerp_pkg::CNT_W-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                func,
  input  wire logic [klerp_pkg::IDX_W-1:0]         entry_index,
  input  wire logic signed [klerp_pkg::KEY_W-1:0]  key_in,
  input  wire logic signed [klerp_pkg::VAL_W-1:0]  value_x_in,
  input  wire logic signed [klerp_pkg::VAL_W-1:0]  value_y_in,
  input  wire logic signed [klerp_pkg::KEY_W-1:0]  fraction,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [klerp_pkg::VAL_W-1:0]       out_x,
  output logic signed [klerp_pkg::VAL_W-1:0]       out_y
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  klerp_pkg::dp_cmd_t    cmd;
  klerp_pkg::dp_status_t status;
  logic [AW-1:0]         rd_addr;

  klerp_ctrl #(
    .MAX_KEYS (MAX_KEYS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .cmd       (cmd),
    .status    (status),
    .rd_addr   (rd_addr)
  );

  klerp_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .rd_addr     (rd_addr),
    .entry_index (entry_index),
    .key_in      (key_in),
    .value_x_in  (value_x_in),
    .value_y_in  (value_y_in),
    .fraction    (fraction),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y)
  );

endmodule

`default_nettype wire

>>> bench/keyframe_lerp_2d_unit_tb.sv
// Self-checking testbench for keyframe_lerp_2d_unit: table writes and evaluations
// with random idling on both channels, checked against an in-bench interpolator.
// Depends on klerp_pkg and the keyframe_lerp_2d_unit RTL.
`timescale 1ns / 1ps

module keyframe_lerp_2d_unit_tb;

  localparam int MAX_KEYS        = klerp_pkg::MAX_KEYS_DEFAULT;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 2_000_000;

  class lerp_scoreboard;
    typedef struct packed {
      logic [klerp_pkg::VAL_W-1:0] x;
      logic [klerp_pkg::VAL_W-1:0] y;
    } point_t;

    logic signed [klerp_pkg::KEY_W-1:0] key_tab [MAX_KEYS];
    logic signed [klerp_pkg::VAL_W-1:0] x_tab [MAX_KEYS];
    logic signed [klerp_pkg::VAL_W-1:0] y_tab [MAX_KEYS];
    logic [klerp_pkg::CNT_W-1:0]        key_cnt = '0;
    logic [klerp_pkg::CNT_W-1:0]        val_cnt = '0;
    point_t                             expected_points [$];
    int                                 mismatches = 0;

    function void set_counts(logic [klerp_pkg::CNT_W-1:0] keys,
                             logic [klerp_pkg::CNT_W-1:0] vals);
      key_cnt = keys;
      val_cnt = vals;
    endfunction

    function logic [klerp_pkg::VAL_W-1:0] blend(logic signed [klerp_pkg::VAL_W-1:0] a,
                                                logic signed [klerp_pkg::VAL_W-1:0] b,
                                                longint t);
      longint d;
      d = longint'(b) - longint'(a);
      return klerp_pkg::VAL_W'(longint'(a) + ((d * t) >>> 16));
    endfunction

    function void note_transaction(logic fn, logic [klerp_pkg::IDX_W-1:0] idx,
                                   logic signed [klerp_pkg::KEY_W-1:0] key,
                                   logic signed [klerp_pkg::VAL_W-1:0] x,
                                   logic signed [klerp_pkg::VAL_W-1:0] y,
                                   logic signed [klerp_pkg::KEY_W-1:0] f);
      int     n, i, lo, hi, kl, kr, fi;
      bit     found;
      longint t;
      point_t p;
      if (fn == klerp_pkg::FUNC_WRITE) begin
        key_tab[idx] = key;
        x_tab[idx]   = x;
        y_tab[idx]   = y;
        return;
      end
      if (key_cnt != val_cnt || key_cnt == 0) return;
      n = (key_cnt > MAX_KEYS) ? MAX_KEYS : int'(key_cnt);
      fi = int'(f);
      lo = 0;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (int'(key_tab[i]) <= fi) begin
          lo = i;
          found = 1'b1;
        end else break;
      end
      if (!found) hi = 0;
      else hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
      t = 0;
      if (lo != hi) begin
        kl = int'(key_tab[lo]);
        kr = int'(key_tab[hi]);
        if (kr > kl && fi >= kl) begin
          t = (longint'(fi - kl) << 16) / longint'(kr - kl);
          if (t > 65535) t = 65535;
        end
      end
      p.x = blend(x_tab[lo], x_tab[hi], t);
      p.y = blend(y_tab[lo], y_tab[hi], t);
      expected_points.push_back(p);
    endfunction

    task report(string what, logic [klerp_pkg::VAL_W-1:0] got,
                logic [klerp_pkg::VAL_W-1:0] want);
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_point(logic [klerp_pkg::VAL_W-1:0] x, logic [klerp_pkg::VAL_W-1:0] y);
      point_t want;
      if (expected_points.size() == 0) begin
        report("out_x, no result pending", x, '0);
        return;
      end
      want = expected_points.pop_front();
      if (x !== want.x) report("out_x", x, want.x);
      if (y !== want.y) report("out_y", y, want.y);
    endtask
  endclass

  logic                               clk;
  logic                               rst;
  logic                               cfg_we;
  logic [klerp_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [klerp_pkg::CNT_W-1:0]        cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic                               func;
  logic [klerp_pkg::IDX_W-1:0]        entry_index;
  logic signed [klerp_pkg::KEY_W-1:0] key_in;
  logic signed [klerp_pkg::VAL_W-1:0] value_x_in;
  logic signed [klerp_pkg::VAL_W-1:0] value_y_in;
  logic signed [klerp_pkg::KEY_W-1:0] fraction;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [klerp_pkg::VAL_W-1:0] out_x;
  logic signed [klerp_pkg::VAL_W-1:0] out_y;

  lerp_scoreboard sb = new();

  bit sender_burst   = 1'b0;
  bit receiver_burst = 1'b0;
  bit hold_off_req   = 1'b0;
  bit holding        = 1'b0;
  int items_total    = 0;
  int keys_loaded    = 1;
  int key_lo         = 0;
  int key_hi         = 0;
  int cycle_count    = 0;

  keyframe_lerp_2d_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .entry_index(entry_index),
    .key_in     (key_in),
    .value_x_in (value_x_in),
    .value_y_in (value_y_in),
    .fraction   (fraction),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_point(out_x, out_y);
    if (!rst && in_valid && in_ready)
      sb.note_transaction(func, entry_index, key_in, value_x_in, value_y_in, fraction);
  end

  function automatic int idle_cycles(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [klerp_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2000) - 1000;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_fraction();
    int r, f;
    r = $urandom_range(0, 9);
    if (r < 7) f = key_lo - 64 + int'($urandom_range(0, key_hi - key_lo + 128));
    else if (r < 8) f = int'(sb.key_tab[$urandom_range(0, keys_loaded - 1)]);
    else f = int'($urandom_range(0, 65535)) - 32768;
    if (f < -32768) f = -32768;
    if (f > 32767) f = 32767;
    return f;
  endfunction

  task automatic send_item(input logic fn, input int idx, input int key,
                           input int x, input int y, input int f);
    int gap;
    in_valid    <= 1'b1;
    func        <= fn;
    entry_index <= klerp_pkg::IDX_W'(idx);
    key_in      <= klerp_pkg::KEY_W'(key);
    value_x_in  <= x;
    value_y_in  <= y;
    fraction    <= klerp_pkg::KEY_W'(f);
    do @(posedge clk); while (!in_ready);
    items_total++;
    gap = idle_cycles(sender_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(input int idx, input int key, input int x, input int y);
    send_item(klerp_pkg::FUNC_WRITE, idx, key, x, y, int'($urandom));
  endtask

  task automatic send_eval(input int f);
    send_item(klerp_pkg::FUNC_EVAL, int'($urandom), int'($urandom), int'($urandom),
              int'($urandom), f);
  endtask

  // sender idle until every pending result is out, then block latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(input int keys, input int vals);
    cfg_we    <= 1'b1;
    cfg_index <= klerp_pkg::REG_KEY_COUNT;
    cfg_data  <= klerp_pkg::CNT_W'(keys);
    @(posedge clk);
    cfg_index <= klerp_pkg::REG_VALUE_COUNT;
    cfg_data  <= klerp_pkg::CNT_W'(vals);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_counts(klerp_pkg::CNT_W'(keys), klerp_pkg::CNT_W'(vals));
  endtask

  // non-descending keys with random spacing, sometimes tightly clustered
  task automatic load_keyframes(input int n);
    int step_max, k, i;
    step_max = 60000 / n;
    if ($urandom_range(0, 2) == 0) step_max = step_max >> $urandom_range(1, 8);
    k = -32768 + int'($urandom_range(0, 4000));
    key_lo = k;
    for (i = 0; i < n; i++) begin
      send_write(i, k, rand_value(), rand_value());
      key_hi = k;
      k += int'($urandom_range(0, step_max));
    end
    keys_loaded = n;
  endtask

  task automatic run_phase(input int keys, input int vals, input int n_items);
    int n, i;
    settle();
    set_counts(keys, vals);
    n = (keys > MAX_KEYS) ? MAX_KEYS : keys;
    if (n == 0) n = 1;
    load_keyframes(n);
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_write($urandom_range(0, MAX_KEYS - 1), $urandom, rand_value(), rand_value());
      else send_eval(pick_fraction());
    end
  endtask

  task automatic directed_cases();
    send_eval(0);
    settle();
    set_counts(2, 2);
    send_write(0, -32768, 32'h8000_0000, 32'h7fff_ffff);
    send_write(1, 32767, 32'h7fff_ffff, 32'h8000_0000);
    send_eval(-32768);
    send_eval(32767);
    send_eval(0);
    send_eval(32766);
    send_eval(-32767);
    send_write(MAX_KEYS - 1, $urandom, rand_value(), rand_value());
    // equal keys
    send_write(0, 100, 1000, -1000);
    send_write(1, 100, -5, 5);
    send_eval(99);
    send_eval(100);
    // descending keys
    send_write(1, 50, -5, 5);
    send_eval(75);
    send_eval(60);
    send_eval(200);
    settle();
    set_counts(3, 3);
    send_write(2, 300, 32'h0001_0000, 32'hffff_0000);
    send_eval(120);
    send_eval(300);
    send_eval(-32768);
  endtask

  // receiver holds off while the sender keeps offering evaluations
  task automatic backpressure_burst();
    int i;
    settle();
    set_counts(4, 4);
    load_keyframes(4);
    in_valid <= 1'b0;
    hold_off_req = 1'b1;
    do @(posedge clk); while (!holding);
    sender_burst = 1'b1;
    for (i = 0; i < 12; i++) send_eval(pick_fraction());
    sender_burst = 1'b0;
  endtask

  initial begin : receiver
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        holding = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else stall = idle_cycles(receiver_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      holding = 1'b0;
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int r, c;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = klerp_pkg::REG_KEY_COUNT;
    cfg_data    = '0;
    in_valid    = 1'b0;
    func        = klerp_pkg::FUNC_WRITE;
    entry_index = '0;
    key_in      = '0;
    value_x_in  = '0;
    value_y_in  = '0;
    fraction    = '0;
    out_ready   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    directed_cases();
    backpressure_burst();
    run_phase(1, 1, 20);
    run_phase(64, 64, 30);
    run_phase(127, 127, 15);
    run_phase(0, 64, 8);
    run_phase(64, 0, 8);

    while (items_total < 600) begin
      r = $urandom_range(0, 9);
      if (r < 6) c = $urandom_range(1, 8);
      else if (r < 8) c = $urandom_range(9, 64);
      else if (r < 9) c = $urandom_range(65, 127);
      else c = $urandom_range(0, 127);
      sender_burst   = ($urandom_range(0, 5) == 0);
      receiver_burst = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) run_phase(c, c ^ (1 << $urandom_range(0, 6)), 10);
      else run_phase(c, c, $urandom_range(15, 40));
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;

    settle();
    if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
